FILE: sv/assert_macros.svh
// Assertion macros for the RTL of the ring relaxation unit.
// Depends on nothing; bodies compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every rising clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");
// condition must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

FILE: sv/rsr_pkg.sv
// Types, constants and register codes of the ring relaxation unit.
// No dependencies.
package rsr_pkg;

	localparam int CELLS     = 8;
	localparam int DATA_W    = 16;
	localparam int IDX_W     = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int LPOS_W    = $clog2(CELLS + 1);
	localparam int OUT_IDX_W = 6;
	localparam int CFG_IDX_W = 3;
	localparam int ITER_W    = 16;
	localparam int INTV_W    = 8;
	localparam bit RING_ODD  = (CELLS % 2) == 1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MODE      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CHK_INTV  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_EXPECTED  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 3'd4;

	localparam logic              MODE_RED_BLACK  = 1'b0;
	localparam logic [ITER_W-1:0] MAX_ITER_RST    = 16'd128;
	localparam logic [INTV_W-1:0] CHK_INTV_RST    = 8'd10;
	localparam logic [DATA_W-1:0] EXPECTED_RST    = 16'd12800;
	localparam logic [DATA_W-1:0] TOLERANCE_RST   = 16'd1280;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_RUN  = 1'b1;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_LOAD,
		CELL_RELAX,
		CELL_SHIFT
	} cell_op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_EMIT
	} state_t;

	// broadcast control from the sequencer to the row of cells
	typedef struct packed {
		cell_op_t          op;
		logic              parity;
		logic              mode;
		logic [LPOS_W-1:0] load_pos;
	} ring_ctrl_t;

	typedef struct packed {
		logic [DATA_W-1:0] expected;
		logic [DATA_W-1:0] tolerance;
	} chk_cfg_t;

endpackage

FILE: sv/ring_stencil_relaxation_unit.sv
// Ring relaxation unit: a row of CELLS cells relaxed in place, red-black or Jacobi.
// A run relaxes one step per cycle (Jacobi: all cells in parallel; red-black: one
// parity per step; each check in the cycle after its step), then CELLS output beats,
// one per cycle while out_ready is high, drained by rotating the ring through cell 0.
// arst_n resets the sequencer and config registers; cell contents are not reset.
// Depends on rsr_pkg, rsr_cell, rsr_ctrl and assert_macros.svh.
`include "assert_macros.svh"

module ring_stencil_relaxation_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        command,
	input  logic [15:0] value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] cell_value,
	output logic [5:0]  cell_index,
	output logic        converged,
	output logic [15:0] steps_taken,
	output logic        last
);
	import rsr_pkg::*;

	ring_ctrl_t        ctrl;
	chk_cfg_t          chk;
	logic [DATA_W-1:0] cell_q   [CELLS];
	logic [DATA_W-1:0] relaxed  [CELLS];
	logic [CELLS-1:0]  ok;
	logic              all_ok;

	assign all_ok = &ok;

	rsr_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.command     (command),
		.all_ok      (all_ok),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.cell_index  (cell_index),
		.converged   (converged),
		.steps_taken (steps_taken),
		.last        (last),
		.ctrl        (ctrl),
		.chk         (chk)
	);

	for (genvar i = 0; i < CELLS; i++) begin : g_cell
		localparam int   LEFT = (i + CELLS - 1) % CELLS;
		localparam int   RGHT = (i + 1) % CELLS;
		localparam logic PAR  = 1'(i % 2);

		cell_op_t          op;
		logic [DATA_W-1:0] right;

		always_comb begin
			unique case (ctrl.op)
				CELL_LOAD:  op = (ctrl.load_pos == LPOS_W'(i)) ? CELL_LOAD : CELL_HOLD;
				CELL_RELAX: op = (ctrl.mode || ctrl.parity == PAR) ? CELL_RELAX : CELL_HOLD;
				default:    op = ctrl.op;
			endcase
		end

		if (i == CELLS - 1) begin : g_wrap
			// odd ring, red-black even step: last cell sees cell 0 already updated
			assign right = (RING_ODD && ctrl.op == CELL_RELAX && !ctrl.mode && !ctrl.parity) ?
				relaxed[0] : cell_q[RGHT];
		end else begin : g_mid
			assign right = cell_q[RGHT];
		end

		rsr_cell u_cell (
			.clk       (clk),
			.op        (op),
			.load_data (value),
			.left      (cell_q[LEFT]),
			.right     (right),
			.chk       (chk),
			.value     (cell_q[i]),
			.relaxed   (relaxed[i]),
			.ok        (ok[i])
		);
	end

	assign cell_value = cell_q[0];

	`ASSERT_NEVER(a_in_out_excl, clk, arst_n, in_ready && out_valid)
	`ASSERT_CLK(a_last_idx, clk, arst_n, last |-> (out_valid && cell_index == OUT_IDX_W'(CELLS - 1)))
	`ASSERT_CLK(a_drain_done, clk, arst_n, (out_valid && out_ready && last) |=> in_ready)
	`ASSERT_CLK(a_conv_steps, clk, arst_n, (out_valid && converged) |-> (steps_taken != '0))

endmodule

FILE: sv/rsr_cell.sv
// One ring cell: holds a Q8.8 value, relaxes it from its neighbors, shifts on drain.
// Depends on rsr_pkg.
module rsr_cell (
	input  logic                     clk,
	input  rsr_pkg::cell_op_t        op,
	input  logic [15:0]              load_data,
	input  logic [15:0]              left,
	input  logic [15:0]              right,
	input  rsr_pkg::chk_cfg_t        chk,
	output logic [15:0]              value,
	output logic [15:0]              relaxed,
	output logic                     ok
);
	import rsr_pkg::*;

	logic [DATA_W-1:0] value_q;
	logic [DATA_W:0]   sum;
	logic [DATA_W-1:0] dev;

	assign sum     = {1'b0, left} + {1'b0, right};
	assign relaxed = sum[DATA_W:1];

	always_ff @(posedge clk) begin
		case (op)
			CELL_HOLD:  value_q <= value_q;
			CELL_LOAD:  value_q <= load_data;
			CELL_RELAX: value_q <= relaxed;
			CELL_SHIFT: value_q <= right;
		endcase
	end

	assign dev   = (value_q >= chk.expected) ? value_q - chk.expected : chk.expected - value_q;
	assign ok    = dev <= chk.tolerance;
	assign value = value_q;

endmodule

FILE: sv/rsr_ctrl.sv
// Sequencer of the ring relaxation unit: config registers, load pointer,
// step and check counters, drain counter. Depends on rsr_pkg.
module rsr_ctrl (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [2:0]               cfg_index,
	input  logic [15:0]              cfg_data,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     command,
	input  logic                     all_ok,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [5:0]               cell_index,
	output logic                     converged,
	output logic [15:0]              steps_taken,
	output logic                     last,
	output rsr_pkg::ring_ctrl_t      ctrl,
	output rsr_pkg::chk_cfg_t        chk
);
	import rsr_pkg::*;

	state_t            state_q, state_nx;
	logic              mode_q;
	logic [ITER_W-1:0] max_iter_q;
	logic [INTV_W-1:0] chk_intv_q;
	logic [DATA_W-1:0] expected_q;
	logic [DATA_W-1:0] tolerance_q;

	logic [LPOS_W-1:0] load_pos_q;
	logic [ITER_W-1:0] step_cnt_q;
	logic [INTV_W-1:0] phase_q;
	logic              chk_q;
	logic              conv_q;
	logic [IDX_W-1:0]  emit_idx_q;

	logic              run_beat;
	logic              load_beat;
	logic              load_room;
	logic              hit;
	logic              stop;
	logic              drain_beat;
	logic              drain_end;
	logic [INTV_W-1:0] intv;
	logic [INTV_W:0]   phase_inc;
	logic [INTV_W-1:0] phase_nx;

	assign load_room  = load_pos_q < LPOS_W'(CELLS);
	assign run_beat   = in_valid && in_ready && (command == CMD_RUN);
	assign load_beat  = in_valid && in_ready && (command == CMD_LOAD);
	// a pending check sees the cells as the previous step left them
	assign hit        = chk_q && all_ok;
	assign stop       = hit || (step_cnt_q >= max_iter_q);
	assign drain_beat = out_valid && out_ready;
	assign drain_end  = emit_idx_q == IDX_W'(CELLS - 1);
	assign intv       = (chk_intv_q == '0) ? INTV_W'(1) : chk_intv_q;
	assign phase_inc  = {1'b0, phase_q} + (INTV_W+1)'(1);
	assign phase_nx   = (phase_inc >= {1'b0, intv}) ? '0 : phase_inc[INTV_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_RED_BLACK;
			max_iter_q  <= MAX_ITER_RST;
			chk_intv_q  <= CHK_INTV_RST;
			expected_q  <= EXPECTED_RST;
			tolerance_q <= TOLERANCE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MODE:      mode_q      <= cfg_data[0];
				REG_MAX_ITER:  max_iter_q  <= cfg_data;
				REG_CHK_INTV:  chk_intv_q  <= cfg_data[INTV_W-1:0];
				REG_EXPECTED:  expected_q  <= cfg_data;
				REG_TOLERANCE: tolerance_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: if (run_beat) state_nx = ST_RUN;
			ST_RUN:  if (stop) state_nx = ST_EMIT;
			ST_EMIT: if (drain_beat && drain_end) state_nx = ST_IDLE;
			default: state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			load_pos_q <= '0;
			step_cnt_q <= '0;
			phase_q    <= '0;
			chk_q      <= 1'b0;
			conv_q     <= 1'b0;
			emit_idx_q <= '0;
		end else begin
			state_q <= state_nx;
			unique case (state_q)
				ST_IDLE: begin
					if (run_beat) begin
						load_pos_q <= '0;
						step_cnt_q <= '0;
						phase_q    <= '0;
						chk_q      <= 1'b0;
						conv_q     <= 1'b0;
						emit_idx_q <= '0;
					end else if (load_beat && load_room) begin
						load_pos_q <= load_pos_q + LPOS_W'(1);
					end
				end
				ST_RUN: begin
					if (stop) begin
						conv_q <= hit;
					end else begin
						step_cnt_q <= step_cnt_q + ITER_W'(1);
						chk_q      <= phase_q == '0;
						phase_q    <= phase_nx;
					end
				end
				ST_EMIT: begin
					if (drain_beat) emit_idx_q <= emit_idx_q + IDX_W'(1);
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		in_ready      = 1'b0;
		out_valid     = 1'b0;
		ctrl.op       = CELL_HOLD;
		ctrl.parity   = step_cnt_q[0];
		ctrl.mode     = mode_q;
		ctrl.load_pos = load_pos_q;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && command == CMD_LOAD && load_room) ctrl.op = CELL_LOAD;
			end
			ST_RUN: begin
				if (!stop) ctrl.op = CELL_RELAX;
			end
			ST_EMIT: begin
				out_valid = 1'b1;
				if (out_ready) ctrl.op = CELL_SHIFT;
			end
			default: ;
		endcase
	end

	assign chk.expected  = expected_q;
	assign chk.tolerance = tolerance_q;
	assign cell_index    = OUT_IDX_W'(emit_idx_q);
	assign converged     = conv_q;
	assign steps_taken   = step_cnt_q;
	assign last          = out_valid && drain_end;

endmodule

FILE: bench/ring_stencil_relaxation_unit_test.sv
// Self-checking bench for ring_stencil_relaxation_unit: directed script, then random traffic.
// Expected cell beats come from an in-bench relaxation predictor. Depends on rsr_pkg and the RTL.
module ring_stencil_relaxation_unit_test;
	import rsr_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 1_000_000;
	localparam int unsigned ITEM_COUNT = 240;

	typedef struct {
		logic [DATA_W-1:0]    value;
		logic [OUT_IDX_W-1:0] index;
		logic                 conv;
		logic [ITER_W-1:0]    steps;
		logic                 last;
	} cell_beat_t;

	typedef enum logic [1:0] {
		ROW_LOAD,
		ROW_RUN,
		ROW_CFG
	} row_kind_t;

	typedef struct {
		row_kind_t            kind;
		logic [CFG_IDX_W-1:0] reg_sel;
		logic [DATA_W-1:0]    data;
		bit                   typed;
		logic [DATA_W-1:0]    want_value;
		logic                 want_conv;
		logic [ITER_W-1:0]    want_steps;
	} script_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [DATA_W-1:0]    cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic                 command = CMD_LOAD;
	logic [DATA_W-1:0]    value = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [DATA_W-1:0]    cell_value;
	logic [OUT_IDX_W-1:0] cell_index;
	logic                 converged;
	logic [ITER_W-1:0]    steps_taken;
	logic                 last;

	ring_stencil_relaxation_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.value(value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cell_value(cell_value),
		.cell_index(cell_index),
		.converged(converged),
		.steps_taken(steps_taken),
		.last(last)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// predictor state: ring contents, load pointer and register copies
	logic [DATA_W-1:0] ring_image [CELLS];
	logic [LPOS_W-1:0] fill_pos = '0;
	logic              sweep_jacobi = MODE_RED_BLACK;
	logic [ITER_W-1:0] iter_limit = MAX_ITER_RST;
	logic [INTV_W-1:0] check_every = CHK_INTV_RST;
	logic [DATA_W-1:0] target = EXPECTED_RST;
	logic [DATA_W-1:0] margin = TOLERANCE_RST;

	cell_beat_t  cells_due [$];
	script_row_t script [$];
	cell_beat_t  head_beat;
	bit          steady = 1'b0;
	int unsigned mismatches = 0;
	int unsigned cycle_count = 0;
	int unsigned items_sent = 0;

	function automatic logic [DATA_W-1:0] midpoint(input logic [DATA_W-1:0] a,
			input logic [DATA_W-1:0] b);
		logic [DATA_W:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		return sum[DATA_W:1];
	endfunction

	// relax the ring image as the block would, then queue one beat per cell
	task automatic predict_relaxation();
		logic [DATA_W-1:0] prior [CELLS];
		logic [DATA_W-1:0] worst, gap;
		int unsigned step, phase, every;
		bit done;
		cell_beat_t beat;
		every = (check_every == 0) ? 1 : check_every;
		step = 0;
		phase = 0;
		done = 1'b0;
		while (step < iter_limit && !done) begin
			if (sweep_jacobi) begin
				prior = ring_image;
				for (int i = 0; i < CELLS; i++)
					ring_image[i] = midpoint(prior[(i + CELLS - 1) % CELLS], prior[(i + 1) % CELLS]);
			end else begin
				// in place: later cells see already updated neighbors
				for (int i = step & 1; i < CELLS; i += 2)
					ring_image[i] = midpoint(ring_image[(i + CELLS - 1) % CELLS],
						ring_image[(i + 1) % CELLS]);
			end
			if (phase == 0) begin
				worst = '0;
				for (int i = 0; i < CELLS; i++) begin
					gap = (ring_image[i] > target) ? ring_image[i] - target : target - ring_image[i];
					if (gap > worst)
						worst = gap;
				end
				if (worst <= margin)
					done = 1'b1;
			end
			step++;
			phase++;
			if (phase >= every)
				phase = 0;
		end
		for (int i = 0; i < CELLS; i++) begin
			beat.value = ring_image[i];
			beat.index = OUT_IDX_W'(i);
			beat.conv = done;
			beat.steps = ITER_W'(step);
			beat.last = (i == CELLS - 1);
			cells_due.push_back(beat);
		end
		fill_pos = '0;
	endtask

	task automatic send_beat(input logic cmd, input logic [DATA_W-1:0] data);
		int unsigned gap;
		gap = 0;
		if (!steady)
			while ($urandom_range(99) < 37)
				gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		value <= data;
		do @(posedge clk); while (!in_ready);
		items_sent++;
		if (cmd == CMD_RUN) begin
			predict_relaxation();
		end else if (fill_pos < CELLS) begin
			ring_image[fill_pos] = data;
			fill_pos++;
		end
	endtask

	task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			REG_MODE: sweep_jacobi = data[0];
			REG_MAX_ITER: iter_limit = data;
			REG_CHK_INTV: check_every = data[INTV_W-1:0];
			REG_EXPECTED: target = data;
			REG_TOLERANCE: margin = data;
			default: ;
		endcase
		@(posedge clk);
	endtask

	// sender stops; wait for every pending cell beat, then pause for a trailing load
	task automatic drain_and_pause();
		in_valid <= 1'b0;
		while (cells_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic note_mismatch(input string what);
		$display("mismatch at cycle %0d: %s", cycle_count, what);
		mismatches++;
	endtask

	task automatic check_field(input string label, input logic [15:0] seen,
			input logic [15:0] wanted);
		if (seen !== wanted)
			note_mismatch($sformatf("%s got %0h expected %0h", label, seen, wanted));
	endtask

	function automatic void stage_load(input logic [DATA_W-1:0] data);
		script_row_t row;
		row = '{ROW_LOAD, REG_MODE, data, 1'b0, '0, 1'b0, '0};
		script.push_back(row);
	endfunction

	function automatic void stage_run(input bit typed, input logic [DATA_W-1:0] want_value,
			input logic want_conv, input logic [ITER_W-1:0] want_steps);
		script_row_t row;
		row = '{ROW_RUN, REG_MODE, '0, typed, want_value, want_conv, want_steps};
		script.push_back(row);
	endfunction

	function automatic void stage_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
		script_row_t row;
		row = '{ROW_CFG, idx, data, 1'b0, '0, 1'b0, '0};
		script.push_back(row);
	endfunction

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("ring_stencil_relaxation_unit regression: fail");
			$finish;
		end
	end

	// output side: compare each accepted beat, then pick next ready
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (cells_due.size() == 0) begin
				note_mismatch($sformatf("unexpected beat for cell %0d", cell_index));
			end else begin
				head_beat = cells_due.pop_front();
				check_field("cell_value", cell_value, head_beat.value);
				check_field("cell_index", 16'(cell_index), 16'(head_beat.index));
				check_field("converged", 16'(converged), 16'(head_beat.conv));
				check_field("steps_taken", steps_taken, head_beat.steps);
				check_field("last", 16'(last), 16'(head_beat.last));
			end
		end
		out_ready <= steady || ($urandom_range(99) >= 37);
	end

	initial begin
		int unsigned pick, loads, phase_no, slot;
		bit near;
		logic [DATA_W-1:0] word;
		cell_beat_t beat;

		for (int i = 0; i < CELLS; i++)
			ring_image[i] = '0;

		// uniform ring at the target: settles on the first check
		for (int i = 0; i < CELLS; i++)
			stage_load(16'd12800);
		stage_run(1'b1, 16'd12800, 1'b1, 16'd1);
		// zero step budget leaves the ring as it is
		stage_reg(REG_MAX_ITER, 16'd0);
		stage_run(1'b1, 16'd12800, 1'b0, 16'd0);
		// full-scale checkerboard, one load past the end of the ring
		for (int i = 0; i < CELLS; i++)
			stage_load((i % 2) ? 16'h0000 : 16'hFFFF);
		stage_load(16'h1234);
		stage_reg(REG_MODE, 16'd1);
		stage_reg(REG_MAX_ITER, 16'd1);
		stage_reg(REG_CHK_INTV, 16'd0);
		stage_reg(REG_EXPECTED, 16'h0000);
		stage_reg(REG_TOLERANCE, 16'hFFFF);
		stage_run(1'b0, '0, 1'b0, '0);
		stage_reg(REG_MODE, 16'd0);
		stage_reg(REG_MAX_ITER, 16'hFFFF);
		stage_reg(REG_CHK_INTV, 16'd255);
		stage_reg(REG_EXPECTED, 16'hFFFF);
		stage_reg(REG_TOLERANCE, 16'h0000);
		stage_run(1'b0, '0, 1'b0, '0);
		// ring stuck at full scale, target zero: runs out the whole step budget
		stage_reg(REG_EXPECTED, 16'h0000);
		stage_run(1'b1, 16'hFFFF, 1'b0, 16'hFFFF);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[r]) begin
			if (script[r].kind == ROW_CFG) begin
				if (!cfg_we)
					drain_and_pause();
				apply_reg(script[r].reg_sel, script[r].data);
			end else begin
				if (cfg_we)
					cfg_we <= 1'b0;
				if (script[r].kind == ROW_LOAD) begin
					send_beat(CMD_LOAD, script[r].data);
				end else begin
					send_beat(CMD_RUN, 16'($urandom));
					if (script[r].typed) begin
						for (int k = 0; k < CELLS; k++) begin
							slot = cells_due.size() - CELLS + k;
							beat = cells_due[slot];
							beat.value = script[r].want_value;
							beat.conv = script[r].want_conv;
							beat.steps = script[r].want_steps;
							cells_due[slot] = beat;
						end
					end
				end
			end
		end

		phase_no = 0;
		while (items_sent < ITEM_COUNT) begin
			drain_and_pause();
			steady = (phase_no == 3);
			apply_reg(REG_MODE, 16'($urandom_range(1)));
			pick = $urandom_range(99);
			apply_reg(REG_MAX_ITER, (pick < 5) ? 16'd0 :
				(pick < 12) ? 16'($urandom_range(200, 400)) : 16'($urandom_range(1, 40)));
			pick = $urandom_range(99);
			apply_reg(REG_CHK_INTV, (pick < 8) ? 16'd0 :
				(pick < 14) ? 16'd255 : 16'($urandom_range(1, 12)));
			pick = $urandom_range(99);
			apply_reg(REG_EXPECTED, (pick < 10) ? 16'h0000 :
				(pick < 20) ? 16'hFFFF : 16'($urandom));
			pick = $urandom_range(99);
			apply_reg(REG_TOLERANCE, (pick < 25) ? 16'($urandom_range(0, 64)) :
				(pick < 35) ? 16'hFFFF : 16'($urandom));
			// unused register slots must be harmless
			if ($urandom_range(3) == 0)
				apply_reg(REG_TOLERANCE + 3'($urandom_range(1, 3)), 16'($urandom));
			cfg_we <= 1'b0;

			repeat ($urandom_range(2, 5)) begin
				if ($urandom_range(7) == 0)
					drain_and_pause();
				pick = $urandom_range(99);
				loads = (pick < 75) ? CELLS :
					(pick < 87) ? $urandom_range(0, CELLS - 1) : $urandom_range(CELLS + 1, CELLS + 3);
				near = ($urandom_range(2) == 0);
				for (int n = 0; n < loads; n++) begin
					pick = $urandom_range(99);
					if (pick < 8)
						word = 16'h0000;
					else if (pick < 16)
						word = 16'hFFFF;
					else if (near)
						word = target ^ 16'($urandom_range(0, 255));
					else
						word = 16'($urandom);
					send_beat(CMD_LOAD, word);
				end
				send_beat(CMD_RUN, 16'($urandom));
			end
			phase_no++;
		end

		drain_and_pause();
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("ring_stencil_relaxation_unit regression: pass");
		else
			$display("ring_stencil_relaxation_unit regression: fail");
		$finish;
	end

endmodule

FILE: ring_stencil_relaxation_unit.f
+incdir+sv
sv/rsr_pkg.sv
sv/rsr_cell.sv
sv/rsr_ctrl.sv
sv/ring_stencil_relaxation_unit.sv
bench/ring_stencil_relaxation_unit_test.sv
